/* rtl/pba_pkg.sv */
// shared types, codes and constants of the page bitmap allocator
package pba_pkg;

    localparam int DEF_MAX_PAGES  = 4096;
    localparam int DEF_FILE_SLOTS = 4;

    localparam int OP_W     = 2;
    localparam int SLOT_W   = 2;
    localparam int PAGE_W   = 12;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 13;
    localparam int MAP_W    = 32;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CNT,
        S_SCAN,
        S_GROW,
        S_CHK,
        S_OUT
    } t_state;

endpackage

/* rtl/page_bitmap_allocator.sv */
// page bitmap allocator top level: per-slot page bitmap in memory, counts in a second memory
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+----------------------------------------
//  request | in        | i_in_valid / o_in_stall    | opcode, file_slot, page_index
//  result  | out       | o_out_valid / i_out_stall  | status, granted_page, pages_total,
//          |           |                            | pages_in_use
//
//  free and check go through count read, map read and result before the next accept;
//  a page past the end of the file, an unknown slot or a refused allocate skips the map read
//  allocate scans the 32-bit map words from word 0 up to the first free page, or reads the
//  word of the new page to grow the file; the one-word-per-cycle map read port sets the pace
//  reset is synchronous and active low; it clears the sequencer, the output valid and the
//  per-slot init flags; a slot whose flag is clear reads as page 0 only, so no clearing pass
//  the result sits in an output register, a new request is taken while it waits; the
//  sequencer only waits in its last state when the output register is still full and stalled
module page_bitmap_allocator #(
    parameter int MAX_PAGES  = pba_pkg::DEF_MAX_PAGES,
    parameter int FILE_SLOTS = pba_pkg::DEF_FILE_SLOTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [pba_pkg::OP_W-1:0]      i_opcode,
    input  logic [pba_pkg::SLOT_W-1:0]    i_file_slot,
    input  logic [pba_pkg::PAGE_W-1:0]    i_page_index,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pba_pkg::STATUS_W-1:0]  o_status,
    output logic [pba_pkg::PAGE_W-1:0]    o_granted_page,
    output logic [pba_pkg::COUNT_W-1:0]   o_pages_total,
    output logic [pba_pkg::COUNT_W-1:0]   o_pages_in_use
);
    import pba_pkg::*;

    // map geometry: each slot owns a whole number of 32-bit words
    localparam int WPS   = (MAX_PAGES + MAP_W - 1) / MAP_W;
    localparam int DEPTH = FILE_SLOTS * WPS;
    localparam int WIW   = (WPS > 1) ? $clog2(WPS) : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SIW   = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
    localparam int CW    = $clog2(MAX_PAGES + 1);

    // page map memory, one read and one write port
    logic [MAP_W-1:0]  map_mem [DEPTH];
    logic [MAP_W-1:0]  map_rd;
    logic              map_re;
    logic [AW-1:0]     map_ra;
    logic              map_we;
    logic [AW-1:0]     map_wa;
    logic [MAP_W-1:0]  map_wd;

    // count memory: {page count, allocated count} per slot
    logic [2*CW-1:0]   cnt_mem [FILE_SLOTS];
    logic [2*CW-1:0]   cnt_rd;
    logic              cnt_re;
    logic              cnt_we;
    logic [2*CW-1:0]   cnt_wd;

    // sequencer and control state
    t_state            r_state, n_state;
    logic              r_o_valid, n_o_valid;
    logic [FILE_SLOTS-1:0] r_init;

    // working registers of the current request
    logic [OP_W-1:0]   r_op, n_op;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [PAGE_W-1:0] r_page, n_page;
    logic [CW-1:0]     r_total, n_total;
    logic [CW-1:0]     r_used, n_used;
    logic [WIW-1:0]    r_w, n_w;

    // pending result, moved to the output register in the last state
    logic [STATUS_W-1:0] r_res_st, n_res_st;
    logic [PAGE_W-1:0]   r_res_gp, n_res_gp;
    logic [CW-1:0]       r_res_pt, n_res_pt;
    logic [CW-1:0]       r_res_pu, n_res_pu;
    logic                load_out;

    // output register
    logic [STATUS_W-1:0] r_o_status;
    logic [PAGE_W-1:0]   r_o_gp;
    logic [COUNT_W-1:0]  r_o_pt;
    logic [COUNT_W-1:0]  r_o_pu;

    // decoded and derived values
    logic [SIW-1:0]    slot_ext;
    logic [SIW-1:0]    in_slot_ext;
    logic              slot_ok;
    logic [CW-1:0]     total_c;
    logic [CW-1:0]     used_c;
    logic [MAP_W-1:0]  eff_word;
    logic [MAP_W-1:0]  beyond_mask;
    logic [MAP_W-1:0]  scan_word;
    logic [31:0]       scan_rem;
    logic [4:0]        free_idx;
    logic [4:0]        grow_bit;
    logic [WIW-1:0]    w_next;

    function automatic logic [AW-1:0] map_addr(input logic [SIW-1:0] s,
                                               input logic [WIW-1:0] w);
        return AW'(32'(s) * WPS + 32'(w));
    endfunction

    // lowest clear bit of a word
    function automatic logic [4:0] low_zero(input logic [MAP_W-1:0] w);
        logic [4:0] idx;
        idx = '0;
        for (int i = MAP_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    assign slot_ext    = SIW'(r_slot);
    assign in_slot_ext = SIW'(i_file_slot);
    assign slot_ok     = (32'(r_slot) < 32'(FILE_SLOTS));

    // a never-written slot holds only the header page, one page, one allocated
    assign total_c = (slot_ok && r_init[slot_ext]) ? cnt_rd[2*CW-1:CW] : CW'(1);
    assign used_c  = (slot_ok && r_init[slot_ext]) ? cnt_rd[CW-1:0]    : CW'(1);

    // word 0 of a never-written slot reads as the header page alone
    assign eff_word = (r_w == '0 && !(slot_ok && r_init[slot_ext])) ? MAP_W'(1) : map_rd;

    // pages at or past the page count look taken to the scan
    assign scan_rem    = 32'(r_total) - 32'(r_w) * MAP_W;
    assign beyond_mask = (scan_rem >= MAP_W) ? '0
                                             : ~((MAP_W'(1) << scan_rem[4:0]) - MAP_W'(1));
    assign scan_word   = eff_word | beyond_mask;
    assign free_idx    = low_zero(scan_word);
    assign grow_bit    = 5'(r_total % MAP_W);
    assign w_next      = r_w + 1'b1;

    // next state and datapath control
    always_comb begin
        n_state   = r_state;
        n_o_valid = r_o_valid && i_out_stall;
        load_out  = 1'b0;
        n_op      = r_op;
        n_slot    = r_slot;
        n_page    = r_page;
        n_total   = r_total;
        n_used    = r_used;
        n_w       = r_w;
        n_res_st  = r_res_st;
        n_res_gp  = r_res_gp;
        n_res_pt  = r_res_pt;
        n_res_pu  = r_res_pu;
        map_re    = 1'b0;
        map_ra    = map_addr(slot_ext, r_w);
        map_we    = 1'b0;
        map_wa    = map_addr(slot_ext, r_w);
        map_wd    = eff_word;
        cnt_re    = 1'b0;
        cnt_we    = 1'b0;
        cnt_wd    = {r_total, r_used};

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_opcode;
                    n_slot  = i_file_slot;
                    n_page  = i_page_index;
                    cnt_re  = 1'b1;
                    n_state = S_CNT;
                end
            end
            S_CNT: begin
                n_total  = total_c;
                n_used   = used_c;
                n_res_gp = r_page;
                n_res_pt = total_c;
                n_res_pu = used_c;
                if (!slot_ok) begin
                    // unknown slot: nothing to report but the page echo
                    n_res_st = ST_INVALID;
                    n_res_pt = '0;
                    n_res_pu = '0;
                    n_state  = S_OUT;
                end else if (r_op == OP_ALLOC) begin
                    n_res_gp = '0;
                    if (used_c < total_c) begin
                        n_w     = '0;
                        map_re  = 1'b1;
                        map_ra  = map_addr(slot_ext, '0);
                        n_state = S_SCAN;
                    end else if (32'(total_c) >= 32'(MAX_PAGES)) begin
                        n_res_st = ST_FULL;
                        n_state  = S_OUT;
                    end else begin
                        n_w     = WIW'(total_c / MAP_W);
                        map_re  = 1'b1;
                        map_ra  = map_addr(slot_ext, WIW'(total_c / MAP_W));
                        n_state = S_GROW;
                    end
                end else begin
                    if (32'(r_page) >= 32'(total_c)) begin
                        n_res_st = ST_INVALID;
                        n_state  = S_OUT;
                    end else begin
                        n_w     = WIW'(r_page / MAP_W);
                        map_re  = 1'b1;
                        map_ra  = map_addr(slot_ext, WIW'(r_page / MAP_W));
                        n_state = S_CHK;
                    end
                end
            end
            S_SCAN: begin
                if (!(&scan_word)) begin
                    map_we   = 1'b1;
                    map_wd   = eff_word | (MAP_W'(1) << free_idx);
                    cnt_we   = 1'b1;
                    cnt_wd   = {r_total, r_used + 1'b1};
                    n_res_st = ST_OK;
                    n_res_gp = PAGE_W'(32'(r_w) * MAP_W + 32'(free_idx));
                    n_res_pt = r_total;
                    n_res_pu = r_used + 1'b1;
                    n_state  = S_OUT;
                end else begin
                    // next word is read while this one is checked
                    n_w    = w_next;
                    map_re = 1'b1;
                    map_ra = map_addr(slot_ext, w_next);
                end
            end
            S_GROW: begin
                // a fresh word holds nothing below the new page
                map_we   = 1'b1;
                map_wd   = ((grow_bit == '0) ? '0 : eff_word) | (MAP_W'(1) << grow_bit);
                cnt_we   = 1'b1;
                cnt_wd   = {r_total + 1'b1, r_used + 1'b1};
                n_res_st = ST_OK;
                n_res_gp = PAGE_W'(r_total);
                n_res_pt = r_total + 1'b1;
                n_res_pu = r_used + 1'b1;
                n_state  = S_OUT;
            end
            S_CHK: begin
                if (!eff_word[r_page[4:0]]) begin
                    n_res_st = ST_INVALID;
                end else begin
                    n_res_st = ST_OK;
                    if (r_op == OP_FREE) begin
                        map_we   = 1'b1;
                        map_wd   = eff_word & ~(MAP_W'(1) << r_page[4:0]);
                        cnt_we   = 1'b1;
                        cnt_wd   = {r_total, r_used - 1'b1};
                        n_res_pu = r_used - 1'b1;
                    end
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_o_valid || !i_out_stall) begin
                    load_out  = 1'b1;
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // page map memory
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        if (map_re) begin
            map_rd <= map_mem[map_ra];
        end
    end

    // count memory
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[slot_ext] <= cnt_wd;
        end
        if (cnt_re) begin
            cnt_rd <= cnt_mem[in_slot_ext];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_init    <= '0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            if (cnt_we) begin
                r_init[slot_ext] <= 1'b1;
            end
        end
    end

    // working, pending and output registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_slot   <= n_slot;
        r_page   <= n_page;
        r_total  <= n_total;
        r_used   <= n_used;
        r_w      <= n_w;
        r_res_st <= n_res_st;
        r_res_gp <= n_res_gp;
        r_res_pt <= n_res_pt;
        r_res_pu <= n_res_pu;
        if (load_out) begin
            r_o_status <= r_res_st;
            r_o_gp     <= r_res_gp;
            r_o_pt     <= COUNT_W'(r_res_pt);
            r_o_pu     <= COUNT_W'(r_res_pu);
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_o_valid;
    assign o_status       = r_o_status;
    assign o_granted_page = r_o_gp;
    assign o_pages_total  = r_o_pt;
    assign o_pages_in_use = r_o_pu;

    // map and counts always change together
    a_map_cnt_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        map_we == cnt_we)
        else $error("page map and count writes out of step");

    // map writes only where a read result is being consumed
    a_map_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        map_we |-> (r_state == S_SCAN || r_state == S_GROW || r_state == S_CHK))
        else $error("page map written outside a read-modify-write state");

    // a scan only runs when a free page is known to exist
    a_scan_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_used < r_total))
        else $error("bitmap scan without a free page below the page count");

    // allocated pages never exceed the page count
    a_used_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pages_in_use <= o_pages_total))
        else $error("allocated count above page count");

    // a full file grants no page and leaves its counts at the limit
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |->
            (o_granted_page == '0 && 32'(o_pages_total) == 32'(MAX_PAGES)))
        else $error("full status with a granted page or a short file");

endmodule

/* dv/page_bitmap_allocator_checker.sv */
// scoreboard for the page bitmap allocator: tracks the page maps and checks every result word
`timescale 1ns / 100ps
module page_bitmap_allocator_checker #(
    parameter int MAX_PAGES  = pba_pkg::DEF_MAX_PAGES,
    parameter int FILE_SLOTS = pba_pkg::DEF_FILE_SLOTS,
    parameter int REPORT_MAX = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_stall,
    input  logic [pba_pkg::OP_W-1:0]      i_opcode,
    input  logic [pba_pkg::SLOT_W-1:0]    i_file_slot,
    input  logic [pba_pkg::PAGE_W-1:0]    i_page_index,
    input  logic                          i_res_valid,
    input  logic                          i_res_stall,
    input  logic [pba_pkg::STATUS_W-1:0]  i_status,
    input  logic [pba_pkg::PAGE_W-1:0]    i_granted_page,
    input  logic [pba_pkg::COUNT_W-1:0]   i_pages_total,
    input  logic [pba_pkg::COUNT_W-1:0]   i_pages_in_use,
    output int                            o_fail_count,
    output int                            o_waiting,
    output int                            o_checked,
    output int                            o_full_count,
    output int                            o_invalid_count
);

    typedef struct packed {
        logic [pba_pkg::STATUS_W-1:0] status;
        logic [pba_pkg::PAGE_W-1:0]   page;
        logic [pba_pkg::COUNT_W-1:0]  total;
        logic [pba_pkg::COUNT_W-1:0]  used;
    } t_reply;

    bit                          page_bits  [FILE_SLOTS][MAX_PAGES];
    logic [pba_pkg::COUNT_W-1:0] file_pages [FILE_SLOTS];
    logic [pba_pkg::COUNT_W-1:0] used_count [FILE_SLOTS];
    t_reply                      pending_replies [$];
    int                          shown;

    function automatic t_reply predict_reply(input logic [pba_pkg::OP_W-1:0] op,
                                             input logic [pba_pkg::SLOT_W-1:0] slot,
                                             input logic [pba_pkg::PAGE_W-1:0] page);
        t_reply r;
        int     p;
        int     hole;
        bit     live;
        r.status = pba_pkg::ST_OK;
        r.page   = page;
        // a slot past the configured count only echoes the page
        if (32'(slot) >= FILE_SLOTS) begin
            r.status = pba_pkg::ST_INVALID;
            r.total  = '0;
            r.used   = '0;
            return r;
        end
        if (op == pba_pkg::OP_ALLOC) begin
            r.page = '0;
            hole   = -1;
            // first fit, only when a hole can exist below the page count
            if (used_count[slot] < file_pages[slot]) begin
                p = 0;
                while (hole < 0 && p < file_pages[slot]) begin
                    if (!page_bits[slot][p])
                        hole = p;
                    p++;
                end
            end
            if (hole >= 0) begin
                page_bits[slot][hole] = 1'b1;
                used_count[slot]      = used_count[slot] + 1'b1;
                r.page                = pba_pkg::PAGE_W'(hole);
            end else if (file_pages[slot] >= MAX_PAGES) begin
                r.status = pba_pkg::ST_FULL;
            end else begin
                // grow the file by one page and hand that page out
                page_bits[slot][file_pages[slot]] = 1'b1;
                r.page                            = file_pages[slot][pba_pkg::PAGE_W-1:0];
                file_pages[slot]                  = file_pages[slot] + 1'b1;
                used_count[slot]                  = used_count[slot] + 1'b1;
            end
        end else begin
            live = (page < file_pages[slot]) && page_bits[slot][page];
            if (!live) begin
                r.status = pba_pkg::ST_INVALID;
            end else if (op == pba_pkg::OP_FREE) begin
                page_bits[slot][page] = 1'b0;
                used_count[slot]      = used_count[slot] - 1'b1;
            end
        end
        r.total = file_pages[slot];
        r.used  = used_count[slot];
        return r;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_reply want;
        t_reply got;
        bit     bad;
        if (!i_rst_n) begin
            for (int s = 0; s < FILE_SLOTS; s++) begin
                for (int p = 0; p < MAX_PAGES; p++)
                    page_bits[s][p] = 1'b0;
                page_bits[s][0] = 1'b1;
                file_pages[s]   = pba_pkg::COUNT_W'(1);
                used_count[s]   = pba_pkg::COUNT_W'(1);
            end
            pending_replies.delete();
            shown           = 0;
            o_fail_count    = 0;
            o_waiting       = 0;
            o_checked       = 0;
            o_full_count    = 0;
            o_invalid_count = 0;
        end else begin
            if (i_res_valid && !i_res_stall) begin
                got.status = i_status;
                got.page   = i_granted_page;
                got.total  = i_pages_total;
                got.used   = i_pages_in_use;
                if (pending_replies.size() == 0) begin
                    o_fail_count++;
                    if (shown < REPORT_MAX)
                        $display("%0t: unexpected result st/pg/tot/use %0d/%0d/%0d/%0d",
                                 $realtime, got.status, got.page, got.total, got.used);
                    shown++;
                end else begin
                    want = pending_replies[0];
                    pending_replies.delete(0);
                    bad  = (got.status !== want.status) || (got.page !== want.page) ||
                           (got.total !== want.total) || (got.used !== want.used);
                    o_checked++;
                    if (want.status == pba_pkg::ST_FULL)
                        o_full_count++;
                    if (want.status == pba_pkg::ST_INVALID)
                        o_invalid_count++;
                    if (bad) begin
                        o_fail_count++;
                        if (shown < REPORT_MAX)
                            $display("%0t: st/pg/tot/use exp %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                                     $realtime, want.status, want.page, want.total, want.used,
                                     got.status, got.page, got.total, got.used);
                        shown++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall)
                pending_replies.insert(pending_replies.size(),
                                       predict_reply(i_opcode, i_file_slot, i_page_index));
            o_waiting = pending_replies.size();
        end
    end

endmodule

/* dv/page_bitmap_allocator_test.sv */
// top of the page bitmap allocator regression: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps
module page_bitmap_allocator_test;

    // opcode 3 has no function of its own and must behave as check
    localparam logic [pba_pkg::OP_W-1:0]   OP_SPARE     = 2'd3;
    // slot that gets grown over many map words
    localparam logic [pba_pkg::SLOT_W-1:0] FILL_SLOT    = 2'd3;
    localparam int MAX_PAGES      = pba_pkg::DEF_MAX_PAGES;
    // grows the slot from 1 page to 601, nineteen map words
    localparam int FILL_WORDS     = 600;
    localparam logic [pba_pkg::PAGE_W-1:0] FILL_LAST = 12'd600;
    localparam logic [pba_pkg::PAGE_W-1:0] FILL_MID  = 12'd300;
    localparam int RANDOM_WORDS   = 1175;
    localparam int PHASES         = 5;
    localparam int RESET_CYCLES   = 7;
    // sized for the longest allocate, which reads one map word per cycle over the whole map
    localparam int DRAIN_CYCLES   = MAX_PAGES / 32 + 64;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic [pba_pkg::OP_W-1:0]      opcode    = '0;
    logic [pba_pkg::SLOT_W-1:0]    file_slot = '0;
    logic [pba_pkg::PAGE_W-1:0]    page_idx  = '0;
    logic                          out_stall = 1'b0;
    logic                          in_stall;
    logic                          out_valid;
    logic [pba_pkg::STATUS_W-1:0]  status;
    logic [pba_pkg::PAGE_W-1:0]    granted_page;
    logic [pba_pkg::COUNT_W-1:0]   pages_total;
    logic [pba_pkg::COUNT_W-1:0]   pages_in_use;

    // percentages of idle sender cycles and stalled receiver cycles
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int words_sent     = 0;
    int quiet_cycles   = 0;

    int fail_count;
    int waiting;
    int checked;
    int full_count;
    int invalid_count;

    always #10 clk = ~clk;

    page_bitmap_allocator dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_opcode       (opcode),
        .i_file_slot    (file_slot),
        .i_page_index   (page_idx),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_status       (status),
        .o_granted_page (granted_page),
        .o_pages_total  (pages_total),
        .o_pages_in_use (pages_in_use)
    );

    page_bitmap_allocator_checker scoreboard (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_req_valid     (in_valid),
        .i_req_stall     (in_stall),
        .i_opcode        (opcode),
        .i_file_slot     (file_slot),
        .i_page_index    (page_idx),
        .i_res_valid     (out_valid),
        .i_res_stall     (out_stall),
        .i_status        (status),
        .i_granted_page  (granted_page),
        .i_pages_total   (pages_total),
        .i_pages_in_use  (pages_in_use),
        .o_fail_count    (fail_count),
        .o_waiting       (waiting),
        .o_checked       (checked),
        .o_full_count    (full_count),
        .o_invalid_count (invalid_count)
    );

    // receiver back-pressure, redrawn every cycle, independent of valid
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // end the run when neither channel moves a word for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, waiting);
            $display("page_bitmap_allocator regression: fail");
            $finish;
        end
    end

    task automatic set_pressure(input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // present one request word, hold it until the block takes it
    task automatic send_word(input logic [pba_pkg::OP_W-1:0]   op,
                             input logic [pba_pkg::SLOT_W-1:0] slot,
                             input logic [pba_pkg::PAGE_W-1:0] page);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        file_slot <= slot;
        page_idx  <= page;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // page numbers lean low so frees and checks mostly hit live pages,
    // with the top of the range and page 0 mixed in
    function automatic logic [pba_pkg::PAGE_W-1:0] pick_page();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return pba_pkg::PAGE_W'($urandom_range(15));
        else if (r < 65)
            return pba_pkg::PAGE_W'($urandom_range(255));
        else if (r < 85)
            return pba_pkg::PAGE_W'($urandom_range(MAX_PAGES - 1));
        else if (r < 93)
            return pba_pkg::PAGE_W'(MAX_PAGES - 1 - $urandom_range(15));
        else
            return '0;
    endfunction

    function automatic logic [pba_pkg::OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return pba_pkg::OP_ALLOC;
        else if (r < 75)
            return pba_pkg::OP_FREE;
        else if (r < 94)
            return pba_pkg::OP_CHECK;
        else
            return OP_SPARE;
    endfunction

    initial begin : stimulus
        int src_mode  [PHASES];
        int sink_mode [PHASES];
        src_mode  = '{0, 54, 0, 15, 0};
        sink_mode = '{0, 0, 54, 15, 0};

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words from the reset state, slots 0 to 2
        set_pressure(0, 0);
        send_word(pba_pkg::OP_CHECK, 2'd0, 12'd0);       // header page is live
        send_word(pba_pkg::OP_CHECK, 2'd0, 12'd1);       // past the end of the file
        send_word(pba_pkg::OP_ALLOC, 2'd0, 12'hABC);     // index ignored, grows to page 1
        send_word(pba_pkg::OP_ALLOC, 2'd0, 12'hFFF);     // grows to page 2
        send_word(pba_pkg::OP_FREE,  2'd0, 12'd1);
        send_word(pba_pkg::OP_FREE,  2'd0, 12'd1);       // already free
        send_word(pba_pkg::OP_CHECK, 2'd0, 12'd1);       // free page is not valid
        send_word(pba_pkg::OP_ALLOC, 2'd0, 12'd0);       // first fit reuses page 1
        send_word(pba_pkg::OP_FREE,  2'd0, 12'd0);       // freeing the header page is allowed
        send_word(pba_pkg::OP_ALLOC, 2'd0, 12'd0);       // and it comes back first
        send_word(OP_SPARE,          2'd1, 12'd0);       // spare opcode acts as check
        send_word(OP_SPARE,          2'd1, 12'hFFF);
        send_word(pba_pkg::OP_FREE,  2'd2, 12'hFFF);     // past the end
        send_word(pba_pkg::OP_FREE,  2'd2, 12'd0);       // slot left with no pages in use
        send_word(pba_pkg::OP_ALLOC, 2'd2, 12'h555);
        send_word(pba_pkg::OP_CHECK, 2'd1, 12'h800);

        // grow one slot across many map words
        for (int i = 0; i < FILL_WORDS; i++)
            send_word(pba_pkg::OP_ALLOC, FILL_SLOT,
                      pba_pkg::PAGE_W'($urandom_range(MAX_PAGES - 1)));

        // holes in a long file: the scan has to walk to the last word
        send_word(pba_pkg::OP_CHECK, FILL_SLOT, FILL_LAST);
        send_word(pba_pkg::OP_FREE,  FILL_SLOT, FILL_LAST);
        send_word(pba_pkg::OP_CHECK, FILL_SLOT, 12'hFFF);  // past the end
        send_word(pba_pkg::OP_ALLOC, FILL_SLOT, 12'd0);    // walks to the last page
        send_word(pba_pkg::OP_ALLOC, FILL_SLOT, 12'd0);    // no hole left, grows
        send_word(pba_pkg::OP_FREE,  FILL_SLOT, 12'd0);
        send_word(pba_pkg::OP_FREE,  FILL_SLOT, FILL_MID);
        send_word(pba_pkg::OP_ALLOC, FILL_SLOT, 12'd0);    // lowest hole first
        send_word(pba_pkg::OP_ALLOC, FILL_SLOT, 12'd0);    // then the middle one

        // random words over all slots, one back-pressure mode per phase
        for (int ph = 0; ph < PHASES; ph++) begin
            set_pressure(src_mode[ph], sink_mode[ph]);
            for (int i = 0; i < RANDOM_WORDS / PHASES; i++)
                send_word(pick_op(), pba_pkg::SLOT_W'($urandom_range(3)), pick_page());
        end

        @(negedge clk);
        in_valid <= 1'b0;
        set_pressure(0, 25);
        while (waiting != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d request words, incl. growing one slot to %0d pages",
                 words_sent, FILL_WORDS + 1);
        $display("%0d results checked: %0d full-file refusals, %0d invalid-page replies",
                 checked, full_count, invalid_count);
        if (fail_count == 0)
            $display("page_bitmap_allocator regression: pass");
        else
            $display("page_bitmap_allocator regression: fail");
        $finish;
    end

endmodule
